/* src/rept_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer package
// Shared widths, register indexes and controller interface types.
// ----------------------------------------------------------------------------
package rept_pkg;

  localparam int TIME_BITS  = 32;
  localparam int PHASE_BITS = 16;
  localparam int RPT_W      = 16;
  localparam int RPT_FRAC   = 8;
  localparam int IDX_W      = 8;
  localparam int CYC_W      = IDX_W + 1;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = PHASE_BITS + RPT_W;
  localparam int CNT_W      = $clog2(PHASE_BITS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TICK   = 3'd0,
    REG_END_TICK     = 3'd1,
    REG_REPEAT_COUNT = 3'd2,
    REG_WINDOW_OPEN  = 3'd3,
    REG_WINDOW_CLOSE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic capture;
    logic load_rel;
    logic step;
    logic take_rel;
    logic scale;
    logic eval;
    logic take_win;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic repeat_zero;
    logic div_last;
    logic need_div;
    logic out_free;
  } dp_status_t;

endpackage

/* src/repeating_effect_phase_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer
// Turns a time value into an active flag, a fractional phase, a repeat cycle
// index and a new-cycle pulse.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  now_tick_i
// output    out        out_valid_o/out_ready_i active_o, phase_o, cycle_index_o,
//                                             new_cycle_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A time outside the effect skips the divider; with repeating disabled the
// serial divider runs once, and with repeating on it may run again for the
// cycle window. It produces one quotient bit per cycle.
// One transaction is in flight at a time; the next input is taken once the
// result sits in the output register, even while that register is stalled.
// Reset clears the configuration to its defaults and the stored cycle to -1.
// ----------------------------------------------------------------------------
module repeating_effect_phase_timer
  import rept_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TIME_BITS-1:0]    now_tick_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    active_o,
  output logic [PHASE_BITS-1:0]   phase_o,
  output logic signed [CYC_W-1:0] cycle_index_o,
  output logic                    new_cycle_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rept_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rept_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .now_tick_i    (now_tick_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .active_o      (active_o),
    .phase_o       (phase_o),
    .cycle_index_o (cycle_index_o),
    .new_cycle_o   (new_cycle_o)
  );

endmodule

/* src/rept_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer controller
// Sequences capture, range check, both divisions, scaling and result hand-off.
// ----------------------------------------------------------------------------
module rept_ctrl
  import rept_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_DIV1   = 8'b0000_0100,
    ST_SCALE  = 8'b0000_1000,
    ST_EVAL   = 8'b0001_0000,
    ST_DIV2   = 8'b0010_0000,
    ST_WINSET = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.in_range) begin
          cmd_o.load_rel = 1'b1;
          state_d        = ST_DIV1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV1: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (status_i.repeat_zero) begin
          cmd_o.take_rel = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.scale = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.need_div ? ST_DIV2 : ST_FINISH;
      end
      ST_DIV2: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_WINSET;
        end
      end
      ST_WINSET: begin
        cmd_o.take_win = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/rept_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer datapath
// Configuration registers, shared fraction divider, repeat multiplier,
// cycle tracking and the output register.
// ----------------------------------------------------------------------------
module rept_dp
  import rept_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [TIME_BITS-1:0]  now_tick_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  active_o,
  output logic [PHASE_BITS-1:0] phase_o,
  output logic signed [CYC_W-1:0] cycle_index_o,
  output logic                  new_cycle_o
);

  logic [TIME_BITS-1:0]  start_q, end_q;
  logic [RPT_W-1:0]      repeat_q;
  logic [PHASE_BITS-1:0] wopen_q, wclose_q;

  logic [TIME_BITS-1:0]  now_q;
  logic [TIME_BITS-1:0]  rem_q, den_q;
  logic [PHASE_BITS-1:0] quo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PROD_W-1:0]     prod_q;
  logic [CYC_W-1:0]      last_q;

  logic                  res_active_q;
  logic [PHASE_BITS-1:0] res_phase_q;
  logic [CYC_W-1:0]      res_idx_q;
  logic                  res_newc_q;

  logic                  out_valid_q;
  logic                  out_active_q;
  logic [PHASE_BITS-1:0] out_phase_q;
  logic [CYC_W-1:0]      out_idx_q;
  logic                  out_newc_q;

  logic [TIME_BITS-1:0]  diff;
  logic                  take;
  logic [IDX_W-1:0]      idx;
  logic [CYC_W-1:0]      idx_ext;
  logic [PHASE_BITS-1:0] frac, win_w, win_n;
  logic                  in_win;

  // Config writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= '0;
      repeat_q <= '0;
      wopen_q  <= '0;
      wclose_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_TICK:   start_q  <= cfg_data_i[TIME_BITS-1:0];
        REG_END_TICK:     end_q    <= cfg_data_i[TIME_BITS-1:0];
        REG_REPEAT_COUNT: repeat_q <= cfg_data_i[RPT_W-1:0];
        REG_WINDOW_OPEN:  wopen_q  <= cfg_data_i[PHASE_BITS-1:0];
        REG_WINDOW_CLOSE: wclose_q <= cfg_data_i[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The remainder stays below the divisor, so doubling it only happens when it fits.
  assign diff = den_q - rem_q;
  assign take = (rem_q >= diff);

  assign idx     = prod_q[PHASE_BITS+RPT_FRAC +: IDX_W];
  assign idx_ext = {1'b0, idx};
  assign frac    = prod_q[RPT_FRAC +: PHASE_BITS];
  assign in_win  = (frac >= wopen_q) && (frac <= wclose_q);
  assign win_w   = wclose_q - wopen_q;
  assign win_n   = frac - wopen_q;

  assign status_o.in_range    = (now_q >= start_q) && (now_q < end_q);
  assign status_o.repeat_zero = (repeat_q == '0);
  assign status_o.div_last    = (cnt_q == CNT_W'(1));
  assign status_o.need_div    = in_win && (win_w != '0) && (win_n < win_w);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q        <= now_tick_i;
      res_active_q <= 1'b0;
      res_phase_q  <= '0;
      res_idx_q    <= '1;
      res_newc_q   <= 1'b0;
    end
    if (cmd_i.load_rel) begin
      rem_q <= now_q - start_q;
      den_q <= end_q - start_q;
      cnt_q <= CNT_W'(PHASE_BITS);
    end else if (cmd_i.eval) begin
      rem_q <= TIME_BITS'(win_n);
      den_q <= TIME_BITS'(win_w);
      cnt_q <= CNT_W'(PHASE_BITS);
    end else if (cmd_i.step) begin
      rem_q <= take ? (rem_q - diff) : {rem_q[TIME_BITS-2:0], 1'b0};
      quo_q <= {quo_q[PHASE_BITS-2:0], take};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.take_rel) begin
      res_active_q <= 1'b1;
      res_phase_q  <= quo_q;
    end
    if (cmd_i.scale) begin
      prod_q <= PROD_W'(quo_q) * PROD_W'(repeat_q);
    end
    if (cmd_i.eval) begin
      res_idx_q  <= idx_ext;
      res_newc_q <= (idx_ext != last_q);
      if (in_win) begin
        res_active_q <= 1'b1;
        res_phase_q  <= (win_w == '0) ? '0 : '1;
      end
    end
    if (cmd_i.take_win) begin
      res_phase_q <= quo_q;
    end
    if (cmd_i.publish) begin
      out_active_q <= res_active_q;
      out_phase_q  <= res_phase_q;
      out_idx_q    <= res_idx_q;
      out_newc_q   <= res_newc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        last_q <= idx_ext;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign active_o      = out_active_q;
  assign phase_o       = out_phase_q;
  assign cycle_index_o = out_idx_q;
  assign new_cycle_o   = out_newc_q;

endmodule

/* src/rept_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer checker
// Port-level properties of the timer, bound to the top level.
// ----------------------------------------------------------------------------
module rept_checker
  import rept_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    active_o,
  input logic [PHASE_BITS-1:0]   phase_o,
  input logic signed [CYC_W-1:0] cycle_index_o,
  input logic                    new_cycle_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o) && $stable(active_o)
      && $stable(cycle_index_o) && $stable(new_cycle_o))
    else $error("output changed while stalled");

  // Only one transaction is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // An inactive result carries a zero phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> phase_o == '0)
    else $error("inactive result with nonzero phase");

  // Without a cycle index there is no new cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_index_o == '1 |-> !new_cycle_o)
    else $error("new cycle flagged without cycle index");

endmodule

bind repeating_effect_phase_timer rept_checker u_rept_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .active_o      (active_o),
  .phase_o       (phase_o),
  .cycle_index_o (cycle_index_o),
  .new_cycle_o   (new_cycle_o)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating effect phase timer testbench
// Sends time values through the valid/ready input and predicts every result
// in a scoreboard that keeps its own copy of the registers and of the stored
// cycle index. Each result is checked field by field. A short directed set
// covers the edges of the effect and of the cycle window. Random phases with
// fresh register settings and both random and sweeping times follow. Both
// channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module tb_top;
  import rept_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 65;

  typedef struct packed {
    logic                    active;
    logic [PHASE_BITS-1:0]   phase;
    logic signed [CYC_W-1:0] cycle;
    logic                    new_cycle;
  } timer_out_t;

  class timer_scoreboard;
    logic [TIME_BITS-1:0]    start_tick;
    logic [TIME_BITS-1:0]    end_tick;
    logic [RPT_W-1:0]        repeat_count;
    logic [PHASE_BITS-1:0]   window_open;
    logic [PHASE_BITS-1:0]   window_close;
    logic signed [CYC_W-1:0] last_cycle;
    timer_out_t              pending[$];
    int                      errors;

    function new();
      start_tick   = '0;
      end_tick     = '0;
      repeat_count = '0;
      window_open  = '0;
      window_close = '1;
      last_cycle   = '1;
      errors       = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_START_TICK:   start_tick   = data[TIME_BITS-1:0];
        REG_END_TICK:     end_tick     = data[TIME_BITS-1:0];
        REG_REPEAT_COUNT: repeat_count = data[RPT_W-1:0];
        REG_WINDOW_OPEN:  window_open  = data[PHASE_BITS-1:0];
        REG_WINDOW_CLOSE: window_close = data[PHASE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Truncated num / den as a fraction; num is always below den here.
    function logic [PHASE_BITS-1:0] ratio(longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (num << PHASE_BITS) / den;
      return q[PHASE_BITS-1:0];
    endfunction

    function void note_time(logic [TIME_BITS-1:0] now);
      timer_out_t              r;
      logic [PHASE_BITS-1:0]   rel;
      logic [PHASE_BITS-1:0]   frac;
      logic [PHASE_BITS-1:0]   width;
      logic [PHASE_BITS-1:0]   offset;
      logic [PROD_W-1:0]       prod;
      r.active    = 1'b0;
      r.phase     = '0;
      r.cycle     = '1;
      r.new_cycle = 1'b0;
      if (now >= start_tick && now < end_tick) begin
        rel = ratio(64'(now - start_tick), 64'(end_tick - start_tick));
        if (repeat_count == 0) begin
          r.active = 1'b1;
          r.phase  = rel;
        end else begin
          prod    = PROD_W'(rel) * PROD_W'(repeat_count);
          frac    = prod[RPT_FRAC +: PHASE_BITS];
          r.cycle = {1'b0, prod[PROD_W-1 -: IDX_W]};
          if (r.cycle != last_cycle) begin
            r.new_cycle = 1'b1;
            last_cycle  = r.cycle;
          end
          if (frac >= window_open && frac <= window_close) begin
            r.active = 1'b1;
            width    = window_close - window_open;
            offset   = frac - window_open;
            if (width == 0) r.phase = '0;
            else if (offset >= width) r.phase = '1;
            else r.phase = ratio(64'(offset), 64'(width));
          end
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic active, logic [PHASE_BITS-1:0] phase,
                               logic [CYC_W-1:0] cycle, logic new_cycle);
      timer_out_t e;
      if (pending.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (active !== e.active) begin
        $error("active mismatch: expected %0d, actual %0d", e.active, active);
        errors++;
      end
      if (phase !== e.phase) begin
        $error("phase mismatch: expected %0d, actual %0d", e.phase, phase);
        errors++;
      end
      if (cycle !== e.cycle) begin
        $error("cycle_index mismatch: expected %0d, actual %0d",
               $signed(e.cycle), $signed(cycle));
        errors++;
      end
      if (new_cycle !== e.new_cycle) begin
        $error("new_cycle mismatch: expected %0d, actual %0d", e.new_cycle, new_cycle);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [TIME_BITS-1:0]    now_tick_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    active_o;
  logic [PHASE_BITS-1:0]   phase_o;
  logic signed [CYC_W-1:0] cycle_index_o;
  logic                    new_cycle_o;

  timer_scoreboard sb = new();
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  repeating_effect_phase_timer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_tick_i    (now_tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .active_o      (active_o),
    .phase_o       (phase_o),
    .cycle_index_o (cycle_index_o),
    .new_cycle_o   (new_cycle_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Outputs and ready only change at the rising edge, so the values seen at
  // the falling edge are the ones the next rising edge will take.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(active_o, phase_o, cycle_index_o, new_cycle_o);
    end
  end

  task automatic send_time(input logic [TIME_BITS-1:0] t);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_tick_i <= t;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_time(t);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_timer(input logic [TIME_BITS-1:0] st, input logic [TIME_BITS-1:0] en,
                               input logic [RPT_W-1:0] rpt, input logic [PHASE_BITS-1:0] wo,
                               input logic [PHASE_BITS-1:0] wc);
    drain();
    write_reg(REG_START_TICK, st);
    write_reg(REG_END_TICK, en);
    write_reg(REG_REPEAT_COUNT, CFG_W'(rpt));
    write_reg(REG_WINDOW_OPEN, CFG_W'(wo));
    write_reg(REG_WINDOW_CLOSE, CFG_W'(wc));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int n, input bit sweep, input bit pause_midway);
    logic [TIME_BITS-1:0]  st;
    logic [TIME_BITS-1:0]  en;
    logic [TIME_BITS-1:0]  now;
    logic [RPT_W-1:0]      rpt;
    logic [PHASE_BITS-1:0] a;
    logic [PHASE_BITS-1:0] b;
    longint unsigned       span;
    longint unsigned       sum;
    case ($urandom_range(0, 3))
      0: st = '0;
      1: st = $urandom;
      2: st = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      default: st = $urandom_range(0, 100000);
    endcase
    case ($urandom_range(0, 5))
      0: en = (st > 100) ? st - $urandom_range(0, 100) : st;
      1: en = '1;
      2: span = 1;
      default: span = $urandom_range(2, 20000);
    endcase
    sum = st + span;
    if ($isunknown(en)) en = (sum > 64'hFFFF_FFFF) ? '1 : sum[TIME_BITS-1:0];
    case ($urandom_range(0, 3))
      0: rpt = '0;
      1: rpt = '1;
      2: rpt = RPT_W'($urandom_range(1, 16'h0400));
      default: rpt = RPT_W'($urandom_range(1, 16'hFFFF));
    endcase
    a = PHASE_BITS'($urandom_range(0, 16'hFFFF));
    b = PHASE_BITS'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 4))
      0: begin a = '0; b = '1; end
      1: b = a;
      2: ;
      default: if (a > b) begin a = b; b = PHASE_BITS'($urandom_range(a, 16'hFFFF)); end
    endcase
    program_timer(st, en, rpt, a, b);
    span = (en > st) ? en - st : 0;
    for (int k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (span != 0 && pick < 8) begin
        sum = sweep ? (span * k) / n : $urandom % span;
        now = st + sum[TIME_BITS-1:0];
      end else if (pick == 8) begin
        case ($urandom_range(0, 3))
          0: now = st - 1;
          1: now = st;
          2: now = en - 1;
          default: now = en;
        endcase
      end else begin
        now = $urandom;
      end
      if (pause_midway && k == n / 2) drain();
      send_time(now);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_START_TICK;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    now_tick_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset settings the effect never opens.
    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);

    program_timer(32'h0, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_time(32'h0000_0000);
    send_time(32'h7FFF_FFFF);
    send_time(32'hFFFF_FFFE);
    send_time(32'hFFFF_FFFF);

    program_timer(32'd1000, 32'd2000, 16'h0300, 16'h0000, 16'hFFFF);
    send_time(32'd999);
    send_time(32'd1000);
    send_time(32'd1333);
    send_time(32'd1334);
    send_time(32'd1500);
    send_time(32'd1666);
    send_time(32'd1667);
    send_time(32'd1999);
    send_time(32'd2000);

    // A zero-width cycle window hit exactly, then just missed.
    program_timer(32'd1000, 32'd2000, 16'h0100, 16'h8000, 16'h8000);
    send_time(32'd1500);
    send_time(32'd1501);

    program_timer(32'd1000, 32'd2000, 16'h0100, 16'h4000, 16'h8000);
    send_time(32'd1250);
    send_time(32'd1375);
    send_time(32'd1500);
    send_time(32'd1600);

    // Window open above close leaves every cycle inactive.
    program_timer(32'd1000, 32'd2000, 16'hFFFF, 16'hC000, 16'h1000);
    send_time(32'd1000);
    send_time(32'd1001);
    send_time(32'd1999);

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p < RAND_PHASES - 2);
      run_random_phase(ITEMS_PER_PHASE, p[0], p == 3);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
